// ----- hw/rtl/rgblbp_pkg.sv -----
package rgblbp_pkg;

  // Synthesis-time limits on the frame geometry.
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // Geometry register reset values, before clamping to the limits.
  localparam int unsigned WIDTH_RESET  = 640;
  localparam int unsigned HEIGHT_RESET = 480;
  localparam int unsigned DIM_MIN      = 3;

  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Luma weights in unsigned Q0.16.
  localparam logic [15:0] W_RED   = 16'd13926;
  localparam logic [15:0] W_GREEN = 16'd46884;
  localparam logic [15:0] W_BLUE  = 16'd4725;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned ACC_W = 24;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [8:0] win_t;

  // Row-major over the 8 neighbours, top-left is the MSB.
  function automatic pix_t lbp_code(input win_t w);
    pix_t code;
    code[7] = (w[4] >= w[0]);
    code[6] = (w[4] >= w[1]);
    code[5] = (w[4] >= w[2]);
    code[4] = (w[4] >= w[3]);
    code[3] = (w[4] >= w[5]);
    code[2] = (w[4] >= w[6]);
    code[1] = (w[4] >= w[7]);
    code[0] = (w[4] >= w[8]);
    return code;
  endfunction

endpackage

// ----- hw/rtl/rgb_to_lbp_code_stream.sv -----
// RGB to 3x3 local binary pattern stream.
// Each pixel passes through the product, line store and window registers before its code
// reaches out_tdata with out_tvalid.
// Throughput: one pixel per cycle; the whole pipeline holds only while a code waits on
// out_tready. Reset (rst_n, synchronous): counters and window clear, geometry returns
// to 640x480; the line store is not cleared and fills during the first two rows.
module rgb_to_lbp_code_stream #(
  parameter int unsigned MAX_WIDTH  = rgblbp_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = rgblbp_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,  // red, green, blue
  input  logic                              in_tuser,  // start_of_frame
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata, // lbp_code
  output logic                              out_tlast, // last_code
  input  logic                              cfg_we,
  input  logic [rgblbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgblbp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CMP_W = rgblbp_pkg::CFG_DATA_W + 1;
  localparam int unsigned W_RST = (rgblbp_pkg::WIDTH_RESET > MAX_WIDTH) ?
                                  MAX_WIDTH : rgblbp_pkg::WIDTH_RESET;
  localparam int unsigned H_RST = (rgblbp_pkg::HEIGHT_RESET > MAX_HEIGHT) ?
                                  MAX_HEIGHT : rgblbp_pkg::HEIGHT_RESET;

  // Geometry, clamped when written.
  logic [WW-1:0] width_r;
  logic [HW-1:0] height_r;
  logic [CMP_W-1:0] cfg_ext;

  assign cfg_ext = {1'b0, cfg_wdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(W_RST);
      height_r <= HW'(H_RST);
    end else if (cfg_we) begin
      if (cfg_index == rgblbp_pkg::REG_IMAGE_WIDTH) begin
        if (cfg_ext < CMP_W'(rgblbp_pkg::DIM_MIN)) width_r <= WW'(rgblbp_pkg::DIM_MIN);
        else if (cfg_ext > CMP_W'(MAX_WIDTH))       width_r <= WW'(MAX_WIDTH);
        else                                        width_r <= WW'(cfg_ext);
      end
      if (cfg_index == rgblbp_pkg::REG_IMAGE_HEIGHT) begin
        if (cfg_ext < CMP_W'(rgblbp_pkg::DIM_MIN)) height_r <= HW'(rgblbp_pkg::DIM_MIN);
        else if (cfg_ext > CMP_W'(MAX_HEIGHT))      height_r <= HW'(MAX_HEIGHT);
        else                                        height_r <= HW'(cfg_ext);
      end
    end
  end

  // Pipeline advances unless a code waits at the output.
  logic en;
  logic accept;
  logic out_tvalid_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;
  assign accept    = in_tvalid && en;

  // Position of the incoming pixel.
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col0, col_cur;
  logic [RW-1:0] row0;
  logic [RW:0]   row_inc;
  logic [RW-1:0] row_cur;
  logic [RW:0]   row_adv;
  logic          col_end, emit_cur, last_cur;

  always_comb begin
    col0 = in_tuser ? '0 : col_r;
    row0 = in_tuser ? '0 : row_r;
    if ({1'b0, col0} >= (CW + 1)'(width_r)) begin
      col_cur = '0;
      row_inc = {1'b0, row0} + (RW + 1)'(1);
    end else begin
      col_cur = col0;
      row_inc = {1'b0, row0};
    end
    row_cur  = (row_inc >= (RW + 1)'(height_r)) ? '0 : RW'(row_inc);
    col_end  = ((WW + 1)'(col_cur) + (WW + 1)'(1)) == (WW + 1)'(width_r);
    row_adv  = {1'b0, row_cur} + (RW + 1)'(1);
    emit_cur = (row_cur >= RW'(2)) && (col_cur >= CW'(2));
    last_cur = col_end && (row_adv == (RW + 1)'(height_r));
    if (col_end) begin
      col_nxt = '0;
      row_nxt = (row_adv >= (RW + 1)'(height_r)) ? '0 : RW'(row_adv);
    end else begin
      col_nxt = col_cur + CW'(1);
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 1: weighted color products.
  logic          v1_r, emit1_r, last1_r, bank1_r;
  logic [CW-1:0] col1_r;
  logic [23:0]   prod_r_r, prod_g_r, prod_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r_r <= 24'(in_tdata[7:0]) * 24'(rgblbp_pkg::W_RED);
      prod_g_r <= 24'(in_tdata[15:8]) * 24'(rgblbp_pkg::W_GREEN);
      prod_b_r <= 24'(in_tdata[23:16]) * 24'(rgblbp_pkg::W_BLUE);
      col1_r   <= col_cur;
      bank1_r  <= row_cur[0];
      emit1_r  <= emit_cur;
      last1_r  <= last_cur;
    end
  end

  // Stage 2: gray value, line store read and write at the same column.
  logic [rgblbp_pkg::ACC_W-1:0] gray_sum;
  rgblbp_pkg::pix_t gray1;
  rgblbp_pkg::pix_t bank0_mem [MAX_WIDTH];
  rgblbp_pkg::pix_t bank1_mem [MAX_WIDTH];
  rgblbp_pkg::pix_t rd0_r, rd1_r, gray2_r;
  logic v2_r, emit2_r, last2_r, bank2_r;

  assign gray_sum = prod_r_r + prod_g_r + prod_b_r;
  assign gray1    = gray_sum[rgblbp_pkg::ACC_W-1 -: rgblbp_pkg::PIX_W];

  // Read returns the old contents when the same entry is written.
  always_ff @(posedge clk) begin
    if (en) begin
      rd0_r <= bank0_mem[col1_r];
      rd1_r <= bank1_mem[col1_r];
      if (v1_r && !bank1_r) bank0_mem[col1_r] <= gray1;
      if (v1_r && bank1_r)  bank1_mem[col1_r] <= gray1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en && v1_r) begin
      gray2_r <= gray1;
      bank2_r <= bank1_r;
      emit2_r <= emit1_r;
      last2_r <= last1_r;
    end
  end

  // Stage 3: window shift and code.
  rgblbp_pkg::win_t win_r, win_nxt;
  rgblbp_pkg::pix_t top, mid;
  rgblbp_pkg::pix_t code_r;
  logic             last_r;

  always_comb begin
    top = bank2_r ? rd1_r : rd0_r;
    mid = bank2_r ? rd0_r : rd1_r;
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = top;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = gray2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      if (v2_r) win_r <= win_nxt;
      out_tvalid_r <= v2_r && emit2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v2_r && emit2_r) begin
      code_r <= rgblbp_pkg::lbp_code(win_nxt);
      last_r <= last2_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = code_r;
  assign out_tlast  = last_r;

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;

  typedef struct packed {
    rgblbp_pkg::pix_t code;
    logic last;
  } lbp_exp_t;

  // One directed transfer: pixel, start flag, and an optional typed-in code.
  typedef struct packed {
    rgblbp_pkg::pix_t red;
    rgblbp_pkg::pix_t green;
    rgblbp_pkg::pix_t blue;
    logic sof;
    logic typed;
    rgblbp_pkg::pix_t code;
    logic last;
  } probe_row_t;

  localparam int unsigned LINE_DEPTH = rgblbp_pkg::MAX_WIDTH_DEF;
  localparam int unsigned PROBE_ROWS = 25;
  localparam int unsigned BIG_FRAME_PIXELS = 150;

  logic                                  clk        = 1'b0;
  logic                                  rst_n      = 1'b0;
  logic                                  in_tvalid  = 1'b0;
  logic                                  in_tready;
  logic [23:0]                           in_tdata   = '0;
  logic                                  in_tuser   = 1'b0;
  logic                                  out_tvalid;
  logic                                  out_tready = 1'b0;
  logic [7:0]                            out_tdata;
  logic                                  out_tlast;
  logic                                  cfg_we     = 1'b0;
  logic [rgblbp_pkg::CFG_IDX_W-1:0]      cfg_index  = rgblbp_pkg::REG_IMAGE_WIDTH;
  logic [rgblbp_pkg::CFG_DATA_W-1:0]     cfg_wdata  = '0;

  rgb_to_lbp_code_stream dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block: line store, window, counters, geometry.
  rgblbp_pkg::pix_t gray_hist [0:2*LINE_DEPTH-1];
  rgblbp_pkg::pix_t win_p [0:8];
  int unsigned col_pos;
  int unsigned row_pos;
  logic [12:0] width_set;
  logic [12:0] height_set;

  lbp_exp_t    pending_codes [$];
  lbp_exp_t    oldest;
  logic [23:0] palette [0:2];
  bit          gaps_on = 1'b1;
  int          stall_left = 0;
  int          mismatches = 0;
  int          pixels_sent = 0;
  int          codes_seen = 0;
  int          settings_used = 0;

  // Frames A and B expect codes typed in; frame C ends on an early start of frame.
  probe_row_t probe_rows [0:PROBE_ROWS-1] = '{
    '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'hFF, 1'b1},
    '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 8'h00, 1'b1},
    '{8'hFF, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0}
  };

  function automatic int unsigned fit_dimension(input logic [12:0] v, input int unsigned hi);
    if (v < rgblbp_pkg::DIM_MIN) return rgblbp_pkg::DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic rgblbp_pkg::pix_t luma8(input rgblbp_pkg::pix_t r,
                                             input rgblbp_pkg::pix_t g,
                                             input rgblbp_pkg::pix_t b);
    logic [23:0] acc;
    acc = r * 24'd13926 + g * 24'd46884 + b * 24'd4725;
    return acc[23:16];
  endfunction

  // Top-left neighbour lands in the MSB; a tie counts as 1.
  function automatic rgblbp_pkg::pix_t window_pattern();
    rgblbp_pkg::pix_t code;
    code = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) code = {code[6:0], win_p[4] >= win_p[k]};
    end
    return code;
  endfunction

  function automatic bit lbp_track(input logic [23:0] rgb, input logic sof,
                                   output lbp_exp_t res);
    int unsigned      w;
    int unsigned      h;
    int unsigned      bank;
    rgblbp_pkg::pix_t gray;
    rgblbp_pkg::pix_t top;
    rgblbp_pkg::pix_t mid;
    bit               hit;
    w = fit_dimension(width_set, rgblbp_pkg::MAX_WIDTH_DEF);
    h = fit_dimension(height_set, rgblbp_pkg::MAX_HEIGHT_DEF);
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    // A geometry that shrank under the counters wraps them first.
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    gray = luma8(rgb[7:0], rgb[15:8], rgb[23:16]);
    bank = row_pos & 1;
    top  = gray_hist[bank * LINE_DEPTH + col_pos];
    mid  = gray_hist[(bank ^ 1) * LINE_DEPTH + col_pos];
    gray_hist[bank * LINE_DEPTH + col_pos] = gray;
    win_p[0] = win_p[1]; win_p[1] = win_p[2];
    win_p[3] = win_p[4]; win_p[4] = win_p[5];
    win_p[6] = win_p[7]; win_p[7] = win_p[8];
    win_p[2] = top;
    win_p[5] = mid;
    win_p[8] = gray;
    res = '0;
    hit = 1'b0;
    if (row_pos >= 2 && col_pos >= 2) begin
      res.code = window_pattern();
      res.last = (row_pos == h - 1) && (col_pos == w - 1);
      hit = 1'b1;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
    return hit;
  endfunction

  function automatic logic [23:0] pick_pixel(input int mode);
    logic [23:0] px;
    px = '0;
    case (mode)
      1: begin
        px = palette[$urandom_range(0, 2)];
      end
      2: begin
        for (int k = 0; k < 3; k++) begin
          if ($urandom_range(0, 1) != 0) px[8*k +: 8] = 8'hFF;
        end
      end
      default: begin
        px = 24'($urandom);
      end
    endcase
    return px;
  endfunction

  task automatic send_pixel(input logic [23:0] rgb, input logic sof,
                            input bit typed, input lbp_exp_t typed_res);
    int       gap;
    lbp_exp_t res;
    bit       hit;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= rgb;
    in_tuser  <= sof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    hit = lbp_track(rgb, sof, res);
    if (typed) pending_codes.push_back(typed_res);
    else if (hit) pending_codes.push_back(res);
    pixels_sent++;
  endtask

  task automatic cfg_put(input logic [rgblbp_pkg::CFG_IDX_W-1:0] idx, input logic [12:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == rgblbp_pkg::REG_IMAGE_WIDTH) width_set = val;
    else height_set = val;
  endtask

  // Drain the pipeline, then write both geometry registers.
  task automatic set_geometry(input logic [12:0] w, input logic [12:0] h);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_put(rgblbp_pkg::REG_IMAGE_WIDTH, w);
    cfg_put(rgblbp_pkg::REG_IMAGE_HEIGHT, h);
    settings_used++;
  endtask

  // The start of a frame at a clamped extreme size.
  task automatic run_big_frame(input logic [12:0] w, input logic [12:0] h);
    int unsigned n;
    gaps_on = ($urandom_range(0, 1) != 0);
    set_geometry(w, h);
    n = fit_dimension(w, rgblbp_pkg::MAX_WIDTH_DEF) *
        fit_dimension(h, rgblbp_pkg::MAX_HEIGHT_DEF);
    if (n > BIG_FRAME_PIXELS) n = BIG_FRAME_PIXELS;
    for (int unsigned p = 0; p < n; p++) send_pixel(pick_pixel(0), p == 0, 1'b0, '0);
  endtask

  // Receiver: while gaps_on is set, stall in bursts of random length.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      codes_seen++;
      if (pending_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 20)
          $display("%0t: expected no code, got code %02h last %0b", $time, out_tdata, out_tlast);
      end else begin
        oldest = pending_codes.pop_front();
        if (oldest.code !== out_tdata || oldest.last !== out_tlast) begin
          mismatches++;
          if (mismatches <= 20)
            $display("%0t: expected code %02h last %0b, got code %02h last %0b",
                     $time, oldest.code, oldest.last, out_tdata, out_tlast);
        end
      end
    end
  end

  initial begin
    int          phase;
    int          frames;
    int          mode;
    int unsigned w;
    int unsigned h;
    int unsigned npx;
    bit          first_sof;
    logic        sof;
    logic [12:0] new_w;
    logic [12:0] new_h;
    lbp_exp_t    typed_res;

    for (int k = 0; k < 2 * LINE_DEPTH; k++) gray_hist[k] = '0;
    for (int k = 0; k < 9; k++) win_p[k] = '0;
    col_pos    = 0;
    row_pos    = 0;
    width_set  = 13'(rgblbp_pkg::WIDTH_RESET);
    height_set = 13'(rgblbp_pkg::HEIGHT_RESET);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: raw sizes below the minimum clamp to 3x3.
    set_geometry(13'd0, 13'd2);
    for (int i = 0; i < PROBE_ROWS; i++) begin
      typed_res.code = probe_rows[i].code;
      typed_res.last = probe_rows[i].last;
      send_pixel({probe_rows[i].blue, probe_rows[i].green, probe_rows[i].red},
                 probe_rows[i].sof, probe_rows[i].typed, typed_res);
    end

    phase = 0;
    while (pixels_sent < 1560) begin
      if (phase == 3) run_big_frame(13'h1FFF, 13'd0);
      if (phase == 7) run_big_frame(13'd1, 13'h1FFF);
      gaps_on   = (pixels_sent < 1350) && ($urandom_range(0, 3) != 0);
      first_sof = ($urandom_range(0, 9) != 0);
      new_w = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 2))
                                           : 13'($urandom_range(3, 14));
      new_h = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 2))
                                           : 13'($urandom_range(3, 8));
      // Hold the width when it would grow under rows already stored mid-frame.
      if (!first_sof && row_pos != 0 &&
          fit_dimension(new_w, rgblbp_pkg::MAX_WIDTH_DEF) >
          fit_dimension(width_set, rgblbp_pkg::MAX_WIDTH_DEF))
        new_w = width_set;
      set_geometry(new_w, new_h);
      w = fit_dimension(new_w, rgblbp_pkg::MAX_WIDTH_DEF);
      h = fit_dimension(new_h, rgblbp_pkg::MAX_HEIGHT_DEF);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        npx = w * h;
        if (f == frames - 1 && $urandom_range(0, 4) == 0) npx = $urandom_range(1, w * h - 1);
        mode = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++)
          palette[k] = ($urandom_range(0, 3) == 0) ? {3{8'hFF}} : 24'($urandom);
        for (int unsigned p = 0; p < npx; p++) begin
          if (p == 0) sof = (f == 0) ? first_sof : ($urandom_range(0, 9) != 0);
          else sof = ($urandom_range(0, 79) == 0);
          send_pixel(pick_pixel(mode), sof, 1'b0, '0);
        end
      end
      phase++;
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    for (int k = 0; k < 50000 && pending_codes.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_codes.size() != 0) begin
      mismatches++;
      $display("%0t: expected %0d more codes, got none", $time, pending_codes.size());
    end

    $display("Sent %0d pixels and checked %0d LBP codes over %0d geometry settings,",
             pixels_sent, codes_seen, settings_used);
    $display("from clamped 3x3 frames to partial frames at the 4096 width and height limits.");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/rgblbp_pkg.sv
hw/rtl/rgb_to_lbp_code_stream.sv
tb/sv/testbench.sv
